// ===== rtl/mhpq_pkg.sv =====
// ----------------------------------------------------------------------------
// mhpq_pkg
// Shared types and constants for the max-heap priority queue: request and
// response beats, the per-cell tap and the broadcast operation.
// ----------------------------------------------------------------------------
`default_nettype none

package mhpq_pkg;

  localparam int unsigned VALUE_W      = 31;
  localparam int unsigned COUNT_W      = 7;
  localparam int unsigned LIMIT_W      = 7;
  localparam int unsigned CAPACITY_DEF = 64;
  localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd64;

  // operation codes
  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  // request beat
  typedef struct packed {
    logic               kind;
    logic [VALUE_W-1:0] value;
  } mhpq_req_t;

  // response beat
  typedef struct packed {
    logic [VALUE_W-1:0] removed_value;
    status_e            status;
    logic [COUNT_W-1:0] count_after;
  } mhpq_rsp_t;

  // operation broadcast to every cell
  typedef struct packed {
    logic               ins;
    logic               rem;
    logic [VALUE_W-1:0] value;
  } mhpq_op_t;

  // what one cell shows its neighbors
  typedef struct packed {
    logic               occ;
    logic               ge;
    logic [VALUE_W-1:0] value;
  } mhpq_tap_t;

endpackage

`default_nettype wire

// ===== rtl/mhpq_cell.sv =====
// ----------------------------------------------------------------------------
// mhpq_cell
// One slot of the sorted chain. Holds one value and an occupied flag; on an
// insert it keeps its value, takes the new value or takes its left neighbor's
// value, on a remove it takes its right neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  mhpq_pkg::mhpq_op_t  op_i,
  input  mhpq_pkg::mhpq_tap_t left_i,
  input  mhpq_pkg::mhpq_tap_t right_i,
  output mhpq_pkg::mhpq_tap_t tap_o
);
  import mhpq_pkg::*;

  logic               occ_q, occ_d;
  logic [VALUE_W-1:0] value_q, value_d;
  logic               ge;

  // stored entry is at least the incoming value, so it stays in place
  assign ge = occ_q && (value_q >= op_i.value);

  assign tap_o.occ   = occ_q;
  assign tap_o.ge    = ge;
  assign tap_o.value = value_q;

  // next slot contents
  always_comb begin
    occ_d   = occ_q;
    value_d = value_q;
    if (op_i.ins) begin
      occ_d = occ_q | left_i.occ;
      if (ge) begin
        value_d = value_q;
      end else if (left_i.ge) begin
        value_d = op_i.value;
      end else begin
        value_d = left_i.value;
      end
    end else if (op_i.rem) begin
      occ_d   = right_i.occ;
      value_d = right_i.value;
    end
  end

  // occupied flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      occ_q <= 1'b0;
    end else begin
      occ_q <= occ_d;
    end
  end

  // slot value
  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

endmodule

`default_nettype wire

// ===== rtl/max_heap_priority_queue.sv =====
// ----------------------------------------------------------------------------
// max_heap_priority_queue
// Priority queue returning the largest stored value, built as a sorted chain
// of cells with the maximum always in the first cell.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: req_i (kind, value) is taken at a clock edge with start_i
//   high and busy_o low. kind insert stores value, kind remove takes out the
//   largest stored value. busy_o stays low, so one request per cycle is taken.
//   Response channel: done_o is high for one cycle, the cycle after the
//   request was taken, with rsp_o carrying the removed value (0 unless a
//   remove succeeded), the status (ok, full, empty) and the count afterwards.
//   Throughput is one request per cycle: every cell compares its entry with
//   the broadcast value and shifts in the same cycle.
//   Configuration: cfg_we_i writes cfg_wdata_i into the capacity limit; the
//   usable depth is the smaller of the limit and CAPACITY. Write it only
//   while no response is pending.
//   Reset clears the count and all occupied flags; the limit returns to 64.
//   The receiver cannot stall: each response is shown for exactly one cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module max_heap_priority_queue #(
  parameter int unsigned CAPACITY = mhpq_pkg::CAPACITY_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start_i,
  output logic                                busy_o,
  input  mhpq_pkg::mhpq_req_t                 req_i,
  output logic                                done_o,
  output mhpq_pkg::mhpq_rsp_t                 rsp_o,
  input  logic                                cfg_we_i,
  input  logic [mhpq_pkg::LIMIT_W-1:0]        cfg_wdata_i
);
  import mhpq_pkg::*;

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned LW = (CW > LIMIT_W) ? CW : LIMIT_W;
  localparam logic [LW-1:0] CAP_L = LW'(CAPACITY);

  logic [LIMIT_W-1:0] limit_q;
  logic [LW-1:0]      count_q, count_d;
  logic               accept, full, empty, ins_ok, rem_ok;
  logic               done_q;
  mhpq_rsp_t          rsp_q, rsp_d;
  mhpq_op_t           op;
  mhpq_tap_t          taps [CAPACITY];
  mhpq_tap_t          left_end, right_end;

  assign busy_o = 1'b0;
  assign accept = start_i && !busy_o;

  // refusal checks against the effective limit
  assign full   = (count_q >= LW'(limit_q)) || (count_q >= CAP_L);
  assign empty  = (count_q == '0);
  assign ins_ok = accept && (req_i.kind == KIND_INSERT) && !full;
  assign rem_ok = accept && (req_i.kind == KIND_REMOVE) && !empty;

  assign op.ins   = ins_ok;
  assign op.rem   = rem_ok;
  assign op.value = req_i.value;

  // chain ends: the head never takes a left neighbor's value, the tail shifts in empty
  assign left_end.occ    = 1'b1;
  assign left_end.ge     = 1'b1;
  assign left_end.value  = '0;
  assign right_end.occ   = 1'b0;
  assign right_end.ge    = 1'b0;
  assign right_end.value = '0;

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    mhpq_tap_t left_s, right_s;
    if (i == 0) begin : g_head
      assign left_s = left_end;
    end else begin : g_left
      assign left_s = taps[i-1];
    end
    if (i == CAPACITY - 1) begin : g_tail
      assign right_s = right_end;
    end else begin : g_right
      assign right_s = taps[i+1];
    end
    mhpq_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .op_i    (op),
      .left_i  (left_s),
      .right_i (right_s),
      .tap_o   (taps[i])
    );
  end

  // count and response
  always_comb begin
    count_d = count_q;
    if (ins_ok) begin
      count_d = count_q + LW'(1);
    end else if (rem_ok) begin
      count_d = count_q - LW'(1);
    end
    rsp_d.removed_value = rem_ok ? taps[0].value : '0;
    if (ins_ok || rem_ok) begin
      rsp_d.status = ST_OK;
    end else if (req_i.kind == KIND_INSERT) begin
      rsp_d.status = ST_FULL;
    end else begin
      rsp_d.status = ST_EMPTY;
    end
    rsp_d.count_after = count_d[COUNT_W-1:0];
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= LIMIT_RESET;
      count_q <= '0;
      done_q  <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        limit_q <= cfg_wdata_i;
      end
      count_q <= count_d;
      done_q  <= accept;
    end
  end

  // response payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign done_o = done_q;
  assign rsp_o  = rsp_q;

endmodule

`default_nettype wire

// ===== rtl/mhpq_checker.sv =====
// ----------------------------------------------------------------------------
// mhpq_checker
// Port-level checks for the priority queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mhpq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start_i,
  input logic                busy_o,
  input logic                done_o,
  input mhpq_pkg::mhpq_rsp_t rsp_o
);
  import mhpq_pkg::*;

  // every taken request answers in the next cycle
  a_resp_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start_i && !busy_o |=> done_o)
    else $error("missing response beat");

  // no response without a request
  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start_i && !busy_o))
    else $error("response beat without request");

  // refused operations return no value
  a_refused_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && (rsp_o.status == ST_FULL || rsp_o.status == ST_EMPTY)
      |-> rsp_o.removed_value == '0)
    else $error("refused beat carries a value");

  // an empty refusal reports an empty queue
  a_empty_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && rsp_o.status == ST_EMPTY |-> rsp_o.count_after == '0)
    else $error("empty refusal with nonzero count");

  // a refusal leaves the count as the previous beat reported it
  a_refused_keeps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && $past(done_o) && rsp_o.status != ST_OK
      |-> rsp_o.count_after == $past(rsp_o.count_after))
    else $error("refusal changed the count");

endmodule

bind max_heap_priority_queue mhpq_checker u_mhpq_checker (
  .clk_i   (clk_i),
  .rst_ni  (rst_ni),
  .start_i (start_i),
  .busy_o  (busy_o),
  .done_o  (done_o),
  .rsp_o   (rsp_o)
);

`default_nettype wire
